// File: sv/pftb_pkg.sv
// shared types and constants of the per-flow token bucket limiter
// no dependencies; used by the interfaces, the top level and the testbench

package pftb_pkg;

  localparam int FLOWS     = 64;
  localparam int FRAC_BITS = 24;
  localparam int FLOW_W    = $clog2(FLOWS);
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 32;
  localparam int BURST_W   = 16;
  localparam int LEVEL_W   = 40;
  localparam int PROD_W    = TIME_W + RATE_W;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [RATE_W-1:0] DEFAULT_RATE =
    RATE_W'(((64'd100 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [BURST_W-1:0] BURST_FALLBACK = BURST_W'(200);
  localparam logic [RATE_W-1:0]  RESET_RATE    = RATE_W'(1678);
  localparam logic [BURST_W-1:0] RESET_BURST   = BURST_W'(200);
  localparam logic [LEVEL_W-1:0] ONE_TOKEN     = LEVEL_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    REQ_ALLOW = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_RESET = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  typedef enum logic [0:0] {
    CFG_REFILL_RATE = 1'b0,
    CFG_BURST_SIZE  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] tokens;
    logic [TIME_W-1:0]  stamp;
  } bucket_t;

endpackage

// File: sv/pftb_req_if.sv
// request channel: valid/ready handshake carrying one request item
// depends on pftb_pkg

interface pftb_req_if;
  logic                        valid;
  logic                        ready;
  pftb_pkg::req_type_t         req_type;
  logic [pftb_pkg::FLOW_W-1:0] flow_index;
  logic [pftb_pkg::TIME_W-1:0] time_now;

  modport source (output valid, req_type, flow_index, time_now, input ready);
  modport sink   (input valid, req_type, flow_index, time_now, output ready);
endinterface

// File: sv/pftb_res_if.sv
// result channel: valid/ready handshake carrying one decision item
// depends on pftb_pkg

interface pftb_res_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [pftb_pkg::LEVEL_W-1:0] token_level;

  modport source (output valid, allowed, token_level, input ready);
  modport sink   (input valid, allowed, token_level, output ready);
endinterface

// File: sv/per_flow_token_bucket_limiter.sv
// Per-flow token bucket limiter: one bucket of Q16.24 tokens and a microsecond
// stamp per flow, refilled by elapsed time times the refill rate and capped at
// the burst size. An accepted request item first reads the bucket table (a
// 64-entry memory with a registered read port, written back with forwarding),
// then refills and decides through one 32x32 multiplier, writing back only
// allow requests. A new item is accepted every cycle while the result register
// drains. No clearing pass is needed after reset: valid bits in flip-flops mark
// the flows that are present.
// depends on pftb_pkg, pftb_req_if, pftb_res_if

module per_flow_token_bucket_limiter (
  input  logic                             clk,
  input  logic                             rst_n,
  pftb_req_if.sink                         in_chan,
  pftb_res_if.source                       out_chan,
  input  logic                             cfg_we,
  input  pftb_pkg::cfg_index_t             cfg_index,
  input  logic [pftb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pftb_pkg::*;

  logic [RATE_W-1:0]  refill_rate_r;
  logic [BURST_W-1:0] burst_size_r;

  bucket_t            bucket_mem [FLOWS];
  logic [FLOWS-1:0]   present_r;

  logic               s1_valid_r;
  req_type_t          s1_req_r;
  logic [FLOW_W-1:0]  s1_idx_r;
  logic [TIME_W-1:0]  s1_now_r;
  bucket_t            rd_r;

  logic               out_valid_r;
  logic               out_allowed_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic               in_acc;
  logic               s2_go;
  logic               wr_en;
  bucket_t            wr_entry;
  logic [RATE_W-1:0]  eff_rate;
  logic [LEVEL_W-1:0] cap;
  logic               hit;
  logic [LEVEL_W-1:0] base;
  logic [TIME_W-1:0]  elapsed;
  logic [PROD_W-1:0]  add;
  logic [LEVEL_W-1:0] room;
  logic [LEVEL_W-1:0] lvl;
  logic               can;
  logic               res_allowed_nxt;
  logic [LEVEL_W-1:0] res_level_nxt;

  assign s2_go         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s2_go;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.allowed     = out_allowed_r;
  assign out_chan.token_level = out_level_r;

  // zero-valued registers fall back to defaults
  assign eff_rate = (refill_rate_r != '0) ? refill_rate_r : DEFAULT_RATE;
  assign cap = LEVEL_W'(((burst_size_r != '0) ? burst_size_r : BURST_FALLBACK)) << FRAC_BITS;

  always_comb begin
    hit     = present_r[s1_idx_r];
    // an absent flow starts full with nothing elapsed
    base    = hit ? rd_r.tokens : cap;
    elapsed = hit ? (s1_now_r - rd_r.stamp) : '0;
    add     = PROD_W'(elapsed) * PROD_W'(eff_rate);
    room    = cap - base;
    if (elapsed == '0) begin
      lvl = base;
    end else if (base >= cap || add >= PROD_W'(room)) begin
      lvl = cap;
    end else begin
      lvl = base + LEVEL_W'(add);
    end
    can = (lvl >= ONE_TOKEN);

    res_allowed_nxt = 1'b0;
    res_level_nxt   = '0;
    unique case (s1_req_r)
      REQ_ALLOW: begin
        res_allowed_nxt = can;
        res_level_nxt   = can ? (lvl - ONE_TOKEN) : lvl;
      end
      REQ_CHECK: begin
        res_allowed_nxt = can;
        res_level_nxt   = lvl;
      end
      REQ_RESET, REQ_CLEAR: begin
        res_allowed_nxt = 1'b0;
        res_level_nxt   = '0;
      end
      default: begin
        res_allowed_nxt = 1'b0;
        res_level_nxt   = '0;
      end
    endcase

    wr_en           = s2_go && (s1_req_r == REQ_ALLOW);
    wr_entry.tokens = res_level_nxt;
    wr_entry.stamp  = s1_now_r;
  end

  // bucket table; a read that meets a write-back to the same flow takes the new data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bucket_mem[s1_idx_r] <= wr_entry;
    end
    if (in_acc) begin
      if (wr_en && s1_idx_r == in_chan.flow_index) begin
        rd_r <= wr_entry;
      end else begin
        rd_r <= bucket_mem[in_chan.flow_index];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refill_rate_r <= RESET_RATE;
      burst_size_r  <= RESET_BURST;
      present_r     <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REFILL_RATE: refill_rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_BURST_SIZE:  burst_size_r  <= cfg_wdata[BURST_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s2_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
        unique case (s1_req_r)
          REQ_ALLOW: present_r[s1_idx_r] <= 1'b1;
          REQ_CHECK: ;
          REQ_RESET: present_r[s1_idx_r] <= 1'b0;
          REQ_CLEAR: present_r <= '0;
          default: ;
        endcase
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_chan.req_type;
      s1_idx_r <= in_chan.flow_index;
      s1_now_r <= in_chan.time_now;
    end
    if (s2_go) begin
      out_allowed_r <= res_allowed_nxt;
      out_level_r   <= res_level_nxt;
    end
  end

endmodule

// File: tb/tb.sv
// self-checking regression for the per-flow token bucket limiter
// holds its own bucket table predictor; depends on pftb_pkg, pftb_req_if, pftb_res_if
`timescale 1ns / 1ps

module tb;
  import pftb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 63;

  typedef struct packed {
    req_type_t         kind;
    logic [FLOW_W-1:0] flow;
    logic [TIME_W-1:0] stamp_us;
  } flow_req_t;

  typedef struct packed {
    logic               allowed;
    logic [LEVEL_W-1:0] token_level;
  } decision_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pftb_req_if req_chan ();
  pftb_res_if res_chan ();

  per_flow_token_bucket_limiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_chan),
    .out_chan  (res_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [RATE_W-1:0]  lim_rate  = RESET_RATE;
  logic [BURST_W-1:0] lim_burst = RESET_BURST;
  logic [LEVEL_W-1:0] bucket_level [FLOWS];
  logic [TIME_W-1:0]  bucket_time  [FLOWS];
  logic [FLOWS-1:0]   bucket_live = '0;

  flow_req_t pending_reqs [$];
  decision_t expected_decisions [$];

  int unsigned n_err = 0;
  logic [TIME_W-1:0] t_cursor = '0;

  // sender and receiver shaping, set per phase by the sequencer
  logic        send_bursty = 1'b0;
  logic [15:0] rx_pat = 16'h0000;
  logic        hold_tog = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_ack = 1'b0;
  logic [3:0]  rx_pos = '0;
  int unsigned idle_cycles = 0;
  flow_req_t   nxt;
  decision_t   want;

  always #5 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] full_level();
    logic [BURST_W-1:0] b;
    b = (lim_burst != '0) ? lim_burst : BURST_FALLBACK;
    return LEVEL_W'(b) << FRAC_BITS;
  endfunction

  function automatic logic [LEVEL_W-1:0] topped_up(logic [LEVEL_W-1:0] level,
                                                   logic [TIME_W-1:0] since,
                                                   logic [TIME_W-1:0] now_us);
    logic [TIME_W-1:0] elapsed;
    logic [63:0] rate, add, cap;
    elapsed = now_us - since;
    if (elapsed == '0) return level;
    rate = (lim_rate != '0) ? 64'(lim_rate) : 64'(DEFAULT_RATE);
    add  = 64'(elapsed) * rate;
    cap  = 64'(full_level());
    if (64'(level) >= cap || add >= cap - 64'(level)) return cap[LEVEL_W-1:0];
    return level + add[LEVEL_W-1:0];
  endfunction

  function automatic decision_t decide(flow_req_t r);
    decision_t d;
    logic [LEVEL_W-1:0] lvl;
    d = '0;
    case (r.kind)
      REQ_CLEAR: bucket_live = '0;
      REQ_RESET: bucket_live[r.flow] = 1'b0;
      REQ_CHECK: begin
        if (!bucket_live[r.flow]) begin
          d = '{1'b1, full_level()};
        end else begin
          lvl = topped_up(bucket_level[r.flow], bucket_time[r.flow], r.stamp_us);
          d = '{lvl >= ONE_TOKEN, lvl};
        end
      end
      REQ_ALLOW: begin
        // an unknown flow starts full at the current time
        if (!bucket_live[r.flow]) begin
          bucket_live[r.flow]  = 1'b1;
          bucket_level[r.flow] = full_level();
          bucket_time[r.flow]  = r.stamp_us;
        end
        lvl = topped_up(bucket_level[r.flow], bucket_time[r.flow], r.stamp_us);
        bucket_time[r.flow] = r.stamp_us;
        if (lvl >= ONE_TOKEN) begin
          lvl = lvl - ONE_TOKEN;
          d.allowed = 1'b1;
        end
        bucket_level[r.flow] = lvl;
        d.token_level = lvl;
      end
    endcase
    return d;
  endfunction

  function automatic flow_req_t random_req(int unsigned hot);
    flow_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.kind = (pick < 58) ? REQ_ALLOW : (pick < 84) ? REQ_CHECK :
             (pick < 97) ? REQ_RESET : REQ_CLEAR;
    // mostly a handful of hot flows so buckets actually drain
    r.flow = ($urandom_range(0, 3) == 0) ? FLOW_W'($urandom) : FLOW_W'(hot + $urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 4) t_cursor = $urandom();
    else if (pick < 8) t_cursor = t_cursor + $urandom_range(1000, 1 << 20);
    else t_cursor = t_cursor + $urandom_range(0, 3);
    r.stamp_us = t_cursor;
    return r;
  endfunction

  task automatic queue_req(req_type_t kind, int unsigned flow, logic [TIME_W-1:0] t_us);
    pending_reqs.push_back('{kind, FLOW_W'(flow), t_us});
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_chan.valid || expected_decisions.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limits(logic [CFG_DATA_W-1:0] rate_word, logic [CFG_DATA_W-1:0] burst_word);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REFILL_RATE;
    cfg_wdata <= rate_word;
    @(posedge clk);
    cfg_index <= CFG_BURST_SIZE;
    cfg_wdata <= burst_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_rate  = rate_word;
    lim_burst = burst_word[BURST_W-1:0];
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_chan.valid <= 1'b0;
    end else begin
      if (req_chan.valid && req_chan.ready) begin
        expected_decisions.push_back(decide('{req_chan.req_type, req_chan.flow_index,
                                               req_chan.time_now}));
      end
      if (!req_chan.valid || req_chan.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          req_chan.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          req_chan.valid      <= 1'b1;
          req_chan.req_type   <= nxt.kind;
          req_chan.flow_index <= nxt.flow;
          req_chan.time_now   <= nxt.stamp_us;
          if (burst_left != 0) burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = send_bursty ? $urandom_range(1, 8) : 0;
          end
        end else begin
          req_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
    end else begin
      if (res_chan.valid && res_chan.ready) begin
        if (expected_decisions.size() == 0) begin
          $error("decision with no request pending: allowed %0d token_level 0x%0h",
                 res_chan.allowed, res_chan.token_level);
          n_err++;
        end else begin
          want = expected_decisions.pop_front();
          if (res_chan.allowed !== want.allowed) begin
            $error("allowed: expected %0d, actual %0d", want.allowed, res_chan.allowed);
            n_err++;
          end
          if (res_chan.token_level !== want.token_level) begin
            $error("token_level: expected 0x%0h, actual 0x%0h",
                   want.token_level, res_chan.token_level);
            n_err++;
          end
        end
      end
      if (hold_tog != hold_ack) begin
        hold_ack  = hold_tog;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_chan.ready <= 1'b0;
      end else begin
        res_chan.ready <= !rx_pat[rx_pos];
        rx_pos = rx_pos + 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_chan.valid && req_chan.ready) || (res_chan.valid && res_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("per_flow_token_bucket_limiter regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned ph, k, hot;
    logic [CFG_DATA_W-1:0] rate_word, burst_word;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REFILL_RATE;
    cfg_wdata = '0;
    req_chan.valid = 1'b0;
    req_chan.req_type = REQ_ALLOW;
    req_chan.flow_index = '0;
    req_chan.time_now = '0;
    res_chan.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: absent flows, zero elapsed, wrapped time, reset and clear
    send_bursty = 1'b1;
    rx_pat = 16'h0a50;
    queue_req(REQ_CHECK, 0, 32'd0);
    queue_req(REQ_ALLOW, 0, 32'd100);
    queue_req(REQ_ALLOW, 0, 32'd100);
    queue_req(REQ_CHECK, 0, 32'd100);
    queue_req(REQ_CHECK, 0, 32'd50);
    queue_req(REQ_ALLOW, 63, 32'hffff_ffff);
    queue_req(REQ_ALLOW, 63, 32'd0);
    queue_req(REQ_RESET, 63, 32'd0);
    queue_req(REQ_CHECK, 63, 32'd0);
    queue_req(REQ_RESET, 5, 32'd7);
    queue_req(REQ_ALLOW, 42, 32'h5555_5555);
    queue_req(REQ_ALLOW, 21, 32'haaaa_aaaa);
    queue_req(REQ_CLEAR, 63, 32'hffff_ffff);
    queue_req(REQ_CHECK, 0, 32'd200);
    drain();

    // one-token bucket at the default rate: runs dry, refill below one token
    set_limits(32'd0, 32'hffff_0001);
    queue_req(REQ_ALLOW, 10, 32'd1000);
    queue_req(REQ_ALLOW, 10, 32'd1000);
    queue_req(REQ_CHECK, 10, 32'd1000);
    queue_req(REQ_CHECK, 10, 32'd1001);
    drain();

    // lowered burst: level kept while no time passes, then cut to the new cap
    set_limits(CFG_DATA_W'(RESET_RATE), 32'd200);
    queue_req(REQ_ALLOW, 20, 32'd7);
    drain();
    set_limits(32'h0100_0000, 32'd2);
    queue_req(REQ_CHECK, 20, 32'd7);
    queue_req(REQ_CHECK, 20, 32'd8);
    queue_req(REQ_ALLOW, 20, 32'd8);
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          rate_word  = 32'd0;
          burst_word = {16'($urandom), 16'd0};
        end
        1: begin
          rate_word  = 32'hffff_ffff;
          burst_word = 32'h0000_ffff;
        end
        2: begin
          rate_word  = 32'd1;
          burst_word = 32'd1;
        end
        3: begin
          rate_word  = 32'h0100_0000;
          burst_word = 32'd2;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: rate_word = $urandom_range(1 << 19, 1 << 23);
            1: rate_word = $urandom();
            default: rate_word = 32'd0;
          endcase
          burst_word = {16'($urandom),
                        ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6))};
        end
      endcase
      set_limits(rate_word, burst_word);
      send_bursty = (ph % 3 != 0) && (ph != 2);
      case (ph % 4)
        0: rx_pat = 16'h0000;
        1: rx_pat = 16'($urandom) & 16'hfffe;
        default: rx_pat = 16'($urandom) & 16'($urandom) & 16'hfffe;
      endcase
      // receiver sits back while the sender keeps pushing, so the block backs up
      if (ph == 2) hold_tog = ~hold_tog;
      hot = $urandom_range(0, FLOWS - 1);
      for (k = 0; k < PHASE_ITEMS; k++) pending_reqs.push_back(random_req(hot));
      drain();
    end

    if (n_err == 0) begin
      $display("per_flow_token_bucket_limiter regression: pass");
    end else begin
      $display("per_flow_token_bucket_limiter regression: fail");
    end
    $finish;
  end

endmodule

// File: per_flow_token_bucket_limiter.f
sv/pftb_pkg.sv
sv/pftb_req_if.sv
sv/pftb_res_if.sv
sv/per_flow_token_bucket_limiter.sv
tb/tb.sv
